// ===== rtl/core/bza_pkg.sv =====
// Shared types and constants for the bitmap zone allocator.
package bza_pkg;

  localparam int ZONE_W          = 16;
  localparam int WORD_BITS       = 64;
  localparam int BIT_IDX_W       = $clog2(WORD_BITS);
  localparam int WORD_ADDR_W     = ZONE_W - BIT_IDX_W;
  localparam int MAP_WORDS       = 1 << WORD_ADDR_W;
  localparam int BLK_W           = 3;
  localparam int BLK_WORD_W      = WORD_ADDR_W - BLK_W;
  localparam int CFG_W           = 4;
  localparam int STATUS_W        = 2;
  localparam int WORD_CNT_W      = WORD_ADDR_W + 1;

  localparam logic [CFG_W-1:0] MAX_MAP_BLOCKS   = CFG_W'(8);
  localparam logic [CFG_W-1:0] RESET_MAP_BLOCKS = CFG_W'(8);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_ZONE   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUT_RANGE = 2'd2;

  typedef struct packed {
    logic clear_step;
    logic scan_init;
    logic scan_run;
    logic hit_capture;
    logic alloc_commit;
    logic alloc_fail;
    logic free_load;
    logic free_reject;
    logic free_commit;
  } bza_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_hit;
    logic scan_exhausted;
    logic zone_out_of_range;
  } bza_status_t;

endpackage

// ===== rtl/core/bitmap_zone_allocator_core.sv =====
// Top level of the bitmap zone allocator: controller plus datapath.
// After reset a clearing pass zeroes the 1024-word bitmap, one word a cycle; busy stays high for it.
// A free passes through a load and a commit state before its done strobe; a rejected free strobes done from idle.
// An allocate reads the bitmap one word a cycle, a rate set by the single memory read port;
// with no free zone it reads all 128 words of every block in use. One request at a time; done is a strobe.
module bitmap_zone_allocator_core import bza_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                opcode,
  input  logic [ZONE_W-1:0]   zone_number,
  output logic                done,
  output logic [ZONE_W-1:0]   zone_result,
  output logic [STATUS_W-1:0] status,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data
);

  bza_cmd_t    cmd;
  bza_status_t stat;

  bza_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .busy   (busy),
    .stat   (stat),
    .cmd    (cmd)
  );

  bza_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .zone_number (zone_number),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .stat        (stat),
    .done        (done),
    .zone_result (zone_result),
    .status      (status)
  );

endmodule

// ===== rtl/core/bza_datapath.sv =====
// Datapath: bitmap memory, search hint, scan pointer, config register and result registers.
module bza_datapath import bza_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [ZONE_W-1:0]     zone_number,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data,
  input  bza_cmd_t              cmd,
  output bza_status_t           stat,
  output logic                  done,
  output logic [ZONE_W-1:0]     zone_result,
  output logic [STATUS_W-1:0]   status
);

  logic [WORD_BITS-1:0]   mem [MAP_WORDS];
  logic [WORD_BITS-1:0]   rd_data;
  logic [WORD_ADDR_W-1:0] rd_addr;
  logic                   wr_en;
  logic [WORD_ADDR_W-1:0] wr_addr;
  logic [WORD_BITS-1:0]   wr_data;

  logic [CFG_W-1:0]       map_blocks;
  logic [CFG_W-1:0]       nblk;
  logic [WORD_CNT_W-1:0]  total_words;

  logic [ZONE_W-1:0]      hint;
  logic [BLK_W-1:0]       start_blk;
  logic [WORD_ADDR_W-1:0] clr_addr;
  logic [WORD_ADDR_W-1:0] scan_addr;
  logic [WORD_CNT_W-1:0]  addr_inc;
  logic [WORD_CNT_W-1:0]  issue_cnt;
  logic                   issue_done;
  logic                   chk_valid;
  logic [WORD_ADDR_W-1:0] chk_addr;
  logic [BIT_IDX_W-1:0]   zero_idx;

  logic [WORD_ADDR_W-1:0] hit_addr;
  logic [BIT_IDX_W-1:0]   hit_bit;
  logic [WORD_BITS-1:0]   hit_word;
  logic [ZONE_W-1:0]      free_zone;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_blocks <= RESET_MAP_BLOCKS;
    end else if (cfg_valid && cfg_ready) begin
      map_blocks <= cfg_data;
    end
  end

  // A block count of zero acts as one, anything above the maximum as the maximum.
  always_comb begin
    if (map_blocks == '0) begin
      nblk = CFG_W'(1);
    end else if (map_blocks > MAX_MAP_BLOCKS) begin
      nblk = MAX_MAP_BLOCKS;
    end else begin
      nblk = map_blocks;
    end
  end

  assign total_words = {nblk, {BLK_WORD_W{1'b0}}};

  assign stat.zone_out_of_range = {1'b0, zone_number[ZONE_W-1 -: BLK_W]} >= nblk;
  assign stat.clear_done        = (clr_addr == '1);

  // The search starts in the block holding the hint, or block 0 if that block is not in use.
  assign start_blk  = ({1'b0, hint[ZONE_W-1 -: BLK_W]} >= nblk) ? '0 : hint[ZONE_W-1 -: BLK_W];
  assign addr_inc   = {1'b0, scan_addr} + WORD_CNT_W'(1);
  assign issue_done = (issue_cnt == total_words);

  always_comb begin
    zero_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rd_data[i]) begin
        zero_idx = BIT_IDX_W'(i);
      end
    end
  end

  assign stat.scan_hit       = chk_valid && (rd_data != '1);
  assign stat.scan_exhausted = issue_done && !chk_valid;

  assign rd_addr = cmd.scan_run ? scan_addr : zone_number[ZONE_W-1 -: WORD_ADDR_W];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    if (cmd.clear_step) begin
      wr_en = 1'b1;
    end else if (cmd.alloc_commit) begin
      wr_en   = 1'b1;
      wr_addr = hit_addr;
      wr_data = hit_word | (WORD_BITS'(1) << hit_bit);
    end else if (cmd.free_commit) begin
      wr_en   = 1'b1;
      wr_addr = free_zone[ZONE_W-1 -: WORD_ADDR_W];
      wr_data = rd_data & ~(WORD_BITS'(1) << free_zone[BIT_IDX_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      hint      <= '0;
      chk_valid <= 1'b0;
      issue_cnt <= '0;
      scan_addr <= '0;
      done      <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + WORD_ADDR_W'(1);
      end
      // Reads stream one word a cycle; the check runs in the cycle after the issue.
      chk_valid <= cmd.scan_run && !issue_done;
      if (cmd.scan_init) begin
        scan_addr <= {start_blk, {BLK_WORD_W{1'b0}}};
        issue_cnt <= '0;
      end else if (cmd.scan_run && !issue_done) begin
        scan_addr <= (addr_inc == total_words) ? '0 : addr_inc[WORD_ADDR_W-1:0];
        issue_cnt <= issue_cnt + WORD_CNT_W'(1);
      end
      if (cmd.alloc_commit) begin
        hint <= {hit_addr, hit_bit};
      end else if (cmd.free_commit && (free_zone < hint)) begin
        hint <= free_zone;
      end
      done <= cmd.alloc_commit || cmd.alloc_fail || cmd.free_reject || cmd.free_commit;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr <= scan_addr;
    if (cmd.hit_capture) begin
      hit_addr <= chk_addr;
      hit_bit  <= zero_idx;
      hit_word <= rd_data;
    end
    if (cmd.free_load) begin
      free_zone <= zone_number;
    end
    if (cmd.alloc_commit) begin
      zone_result <= {hit_addr, hit_bit};
      status      <= STATUS_OK;
    end else if (cmd.free_commit) begin
      zone_result <= free_zone;
      status      <= STATUS_OK;
    end else if (cmd.alloc_fail) begin
      zone_result <= '0;
      status      <= STATUS_NO_ZONE;
    end else if (cmd.free_reject) begin
      zone_result <= '0;
      status      <= STATUS_OUT_RANGE;
    end
  end

endmodule

// ===== rtl/core/bza_ctrl.sv =====
// Controller state machine sequencing clear, allocate scan and free requests.
module bza_ctrl import bza_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        opcode,
  output logic        busy,
  input  bza_status_t stat,
  output bza_cmd_t    cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_ALLOC = 3'd3;
  localparam logic [2:0] ST_FREE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (opcode == OP_ALLOC) begin
            cmd.scan_init = 1'b1;
            state_next    = ST_SCAN;
          end else if (stat.zone_out_of_range) begin
            cmd.free_reject = 1'b1;
          end else begin
            cmd.free_load = 1'b1;
            state_next    = ST_FREE;
          end
        end
      end
      ST_SCAN: begin
        priority if (stat.scan_hit) begin
          cmd.hit_capture = 1'b1;
          state_next      = ST_ALLOC;
        end else if (stat.scan_exhausted) begin
          cmd.alloc_fail = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      ST_ALLOC: begin
        cmd.alloc_commit = 1'b1;
        state_next       = ST_IDLE;
      end
      ST_FREE: begin
        cmd.free_commit = 1'b1;
        state_next      = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the bitmap zone allocator core with a predicting scoreboard.
module tb;
  import bza_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ZONES_PER_BLOCK = 1 << (BLK_WORD_W + BIT_IDX_W);
  localparam int ZONE_SPACE      = 1 << ZONE_W;
  localparam int WATCHDOG_LIMIT  = 8000;
  localparam int PHASE_REQUESTS  = 165;

  typedef struct packed {
    logic [ZONE_W-1:0]   zone;
    logic [STATUS_W-1:0] status;
  } zone_reply_t;

  class zone_scoreboard;
    bit [WORD_BITS-1:0] map_words [MAP_WORDS];
    int                 hint;
    logic [CFG_W-1:0]   block_cfg;
    zone_reply_t        replies_due [$];
    logic [ZONE_W-1:0]  held_zones [$];
    int                 errors;

    function new();
      hint      = 0;
      block_cfg = RESET_MAP_BLOCKS;
      errors    = 0;
    endfunction

    function int active_blocks();
      int nblk;
      nblk = block_cfg;
      if (nblk == 0) nblk = 1;
      if (nblk > MAX_MAP_BLOCKS) nblk = MAX_MAP_BLOCKS;
      return nblk;
    endfunction

    function int zone_limit();
      int lim;
      lim = active_blocks() * ZONES_PER_BLOCK;
      return (lim > ZONE_SPACE) ? ZONE_SPACE : lim;
    endfunction

    // Block bounds are always whole words, so the search walks word by word.
    function int lowest_free(int lo, int hi);
      for (int w = lo / WORD_BITS; w < hi / WORD_BITS; w++) begin
        if (~map_words[w] != '0) begin
          for (int b = 0; b < WORD_BITS; b++) begin
            if (!map_words[w][b]) return w * WORD_BITS + b;
          end
        end
      end
      return hi;
    endfunction

    function void note_request(logic op, logic [ZONE_W-1:0] zn);
      zone_reply_t want;
      int          nblk;
      int          limit;
      int          blk;
      int          lo;
      int          hi;
      int          z;
      bit          found;
      nblk  = active_blocks();
      limit = zone_limit();
      want.zone = '0;
      if (op == OP_ALLOC) begin
        want.status = STATUS_NO_ZONE;
        blk = hint / ZONES_PER_BLOCK;
        if (blk >= nblk) blk = 0;
        found = 1'b0;
        for (int i = 0; i < nblk && !found; i++) begin
          lo = blk * ZONES_PER_BLOCK;
          hi = lo + ZONES_PER_BLOCK;
          if (hi > limit) hi = limit;
          if (lo < hi) begin
            z = lowest_free(lo, hi);
            if (z < hi) begin
              map_words[z / WORD_BITS][z % WORD_BITS] = 1'b1;
              hint        = z;
              want.zone   = ZONE_W'(z);
              want.status = STATUS_OK;
              held_zones.push_back(ZONE_W'(z));
              found = 1'b1;
            end
          end
          blk = (blk + 1) % nblk;
        end
      end else if (int'(zn) >= limit) begin
        want.status = STATUS_OUT_RANGE;
      end else begin
        map_words[zn / WORD_BITS][zn % WORD_BITS] = 1'b0;
        if (int'(zn) < hint) hint = zn;
        want.zone   = zn;
        want.status = STATUS_OK;
      end
      replies_due.push_back(want);
    endfunction

    function void check_result(logic [ZONE_W-1:0] zone, logic [STATUS_W-1:0] status);
      zone_reply_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: result with no request outstanding, zone_result %h status %0d",
                 $time, zone, status);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (zone !== want.zone) begin
        $display("%0t: zone_result mismatch, expected %h, actual %h", $time, want.zone, zone);
        errors++;
      end
      if (status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status, status);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst         = 1'b1;
  logic                start       = 1'b0;
  logic                busy;
  logic                opcode      = OP_ALLOC;
  logic [ZONE_W-1:0]   zone_number = '0;
  logic                done;
  logic [ZONE_W-1:0]   zone_result;
  logic [STATUS_W-1:0] status;
  logic                cfg_valid   = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data    = '0;

  zone_scoreboard board = new();
  int             idle_pct = 0;

  bitmap_zone_allocator_core DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .zone_number (zone_number),
    .done        (done),
    .zone_result (zone_result),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_result(zone_result, status);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Start stays high from one request to the next unless an idle gap is drawn.
  task automatic send_request(input logic op, input logic [ZONE_W-1:0] zn);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    opcode      <= op;
    zone_number <= zn;
    do @(posedge clk); while (busy);
    board.note_request(op, zn);
  endtask

  task automatic write_block_count(input logic [CFG_W-1:0] value);
    start <= 1'b0;
    while (board.replies_due.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.block_cfg = value;
  endtask

  task automatic random_request();
    int               pick;
    int               idx;
    logic [ZONE_W-1:0] zn;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      send_request(OP_ALLOC, ZONE_W'($urandom()));
    end else if (pick < 80 && board.held_zones.size() != 0) begin
      idx = $urandom_range(0, board.held_zones.size() - 1);
      zn  = board.held_zones[idx];
      board.held_zones.delete(idx);
      send_request(OP_FREE, zn);
    end else if (pick < 90) begin
      send_request(OP_FREE, ZONE_W'($urandom_range(0, board.zone_limit() - 1)));
    end else begin
      send_request(OP_FREE, ZONE_W'($urandom()));
    end
  endtask

  initial begin : stimulus
    int block_settings [8];
    int idle_modes [4];
    block_settings = '{8, 1, 15, 2, 0, 5, 8, 3};
    idle_modes     = '{0, 72, 0, 7};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed requests at the reset block count, then the clamped counts.
    send_request(OP_ALLOC, '1);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, 16'h5A5A);
    send_request(OP_FREE, 16'd1);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 16'd2);
    send_request(OP_FREE, 16'd2);
    send_request(OP_FREE, '1);
    send_request(OP_ALLOC, '0);

    write_block_count(4'd0);
    send_request(OP_FREE, 16'(ZONES_PER_BLOCK));
    send_request(OP_FREE, '1);
    send_request(OP_FREE, 16'(ZONES_PER_BLOCK - 1));
    send_request(OP_ALLOC, '0);

    write_block_count(4'd15);
    send_request(OP_FREE, '1);
    send_request(OP_ALLOC, '0);

    // With one block in use a free just past it is rejected.
    write_block_count(4'd1);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 16'(ZONES_PER_BLOCK));

    write_block_count(4'd3);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 16'(3 * ZONES_PER_BLOCK));
    write_block_count(4'd2);
    send_request(OP_ALLOC, '0);

    for (int p = 0; p < 8; p++) begin
      write_block_count((p == 6) ? CFG_W'($urandom_range(0, 15)) : CFG_W'(block_settings[p]));
      idle_pct = idle_modes[p % 4];
      repeat (PHASE_REQUESTS) random_request();
    end

    start <= 1'b0;
    while (board.replies_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
